/* rtl/tle_pkg.sv */
package tle_pkg;

    // Control characters and the bytes of the erase sequences
    localparam logic [7:0] CH_BELL       = 8'h07;
    localparam logic [7:0] CH_BS         = 8'h08;
    localparam logic [7:0] CH_LF         = 8'h0a;
    localparam logic [7:0] CH_FF         = 8'h0c;
    localparam logic [7:0] CH_CR         = 8'h0d;
    localparam logic [7:0] CH_KILL_LINE  = 8'h15;
    localparam logic [7:0] CH_KILL_WORD  = 8'h17;
    localparam logic [7:0] CH_ESC        = 8'h1b;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_LBRACKET   = 8'h5b;
    localparam logic [7:0] CH_LETTER_D   = 8'h44;
    localparam logic [7:0] CH_LETTER_K   = 8'h4b;
    localparam logic [7:0] CH_DIGIT_BASE = 8'h30;

    localparam logic [5:0] CAPACITY_RESET = 6'd32;

    localparam logic KIND_ECHO = 1'b0;
    localparam logic KIND_LINE = 1'b1;

    typedef enum logic [2:0]
    {
        RX_BS,
        RX_CR,
        RX_FF,
        RX_KILL_LINE,
        RX_KILL_WORD,
        RX_OTHER
    } rx_class_t;

    typedef enum logic [3:0]
    {
        SRC_BELL,
        SRC_BS,
        SRC_SPACE,
        SRC_LF,
        SRC_FF,
        SRC_ESC,
        SRC_LBRACKET,
        SRC_LETTER_D,
        SRC_LETTER_K,
        SRC_RX,
        SRC_MEM,
        SRC_TENS,
        SRC_ONES
    } src_sel_t;

    typedef enum logic [2:0]
    {
        PTR_HOLD,
        PTR_ZERO,
        PTR_LOAD_LEN,
        PTR_INC,
        PTR_DEC
    } ptr_op_t;

    typedef enum logic [2:0]
    {
        LEN_HOLD,
        LEN_ZERO,
        LEN_DEC,
        LEN_APPEND,
        LEN_FROM_PTR
    } len_op_t;

    typedef enum logic [1:0]
    {
        NUM_HOLD,
        NUM_LEN,
        NUM_LEN_MINUS_PTR
    } num_op_t;

    typedef enum logic [4:0]
    {
        S_IDLE,
        S_DISPATCH,
        S_BS_SPACE,
        S_BS_END,
        S_CR_DATA,
        S_CR_LF,
        S_KW_BLANK,
        S_KW_WORD,
        S_ER_ESC1,
        S_ER_LBR1,
        S_ER_TENS,
        S_ER_ONES,
        S_ER_D,
        S_ER_ESC2,
        S_ER_LBR2,
        S_ER_K
    } state_t;

    typedef struct packed
    {
        logic     emit;
        src_sel_t src;
        logic     kind;
        logic     last;
        ptr_op_t  ptr_op;
        len_op_t  len_op;
        num_op_t  num_op;
        logic     rd_back;
    } cmd_t;

    typedef struct packed
    {
        rx_class_t rx_class;
        logic      len_zero;
        logic      len_below_limit;
        logic      ptr_zero;
        logic      ptr_at_end;
        logic      mem_blank;
        logic      tens_zero;
        logic      slot_free;
    } status_t;

    function automatic logic is_blank(input logic [7:0] c);
        return ((c >= 8'h09) && (c <= 8'h0d)) || (c == CH_SPACE);
    endfunction

    function automatic rx_class_t classify(input logic [7:0] c);
        rx_class_t r;
        priority case (c)
            CH_BS:        r = RX_BS;
            CH_CR:        r = RX_CR;
            CH_FF:        r = RX_FF;
            CH_KILL_LINE: r = RX_KILL_LINE;
            CH_KILL_WORD: r = RX_KILL_WORD;
            default:      r = RX_OTHER;
        endcase
        return r;
    endfunction

endpackage

/* rtl/tle_if.sv */
interface tle_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface tle_tx_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output kind, output out_byte, output last, input ready);
    modport sink (input valid, input kind, input out_byte, input last, output ready);
endinterface

/* rtl/terminal_line_editor_top.sv */
// A request is taken in idle and decoded in dispatch, which loads the first result for a
// plain byte, form feed or backspace; carriage return first reads the line, kill-line first
// latches the erase count, and kill-word first scans back one character a cycle.
// Requests are taken only in idle, so a new request waits until the last result of the one
// before is loaded; kill-word on an empty line gives no result.
// Reset (rst_n, async low) empties the line and sets the capacity to 32; RAM is not cleared.
module terminal_line_editor_top
    import tle_pkg::*;
#(
    parameter int LINE_DEPTH = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       line_capacity_we,
    input  logic [5:0] line_capacity_wdata,
    tle_rx_if.sink     rx,
    tle_tx_if.source   tx
);

    // Command and status between sequencer and datapath
    cmd_t    cmd;
    status_t st;
    logic    in_ready;
    logic    in_accept;

    // Take a request only while the sequencer is idle; the result register
    // keeps the last result for the sink in the meantime.
    assign rx.ready  = in_ready;
    assign in_accept = rx.valid && in_ready;

    // Sequencer: decode the request and step through its result bytes
    tle_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // Datapath: line RAM, length, scan pointer, erase count, result register
    tle_datapath #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_datapath
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .line_capacity_we    (line_capacity_we),
        .line_capacity_wdata (line_capacity_wdata),
        .in_accept           (in_accept),
        .in_byte             (rx.rx_byte),
        .cmd                 (cmd),
        .st                  (st),
        .tx_valid            (tx.valid),
        .tx_ready            (tx.ready),
        .tx_kind             (tx.kind),
        .tx_byte             (tx.out_byte),
        .tx_last             (tx.last)
    );

endmodule

/* rtl/tle_ctrl.sv */
module tle_ctrl
    import tle_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t st,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd.emit    = 1'b0;
        cmd.src     = SRC_BELL;
        cmd.kind    = KIND_ECHO;
        cmd.last    = 1'b0;
        cmd.ptr_op  = PTR_HOLD;
        cmd.len_op  = LEN_HOLD;
        cmd.num_op  = NUM_HOLD;
        cmd.rd_back = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    state_next = S_DISPATCH;
            end

            S_DISPATCH:
            begin
                unique case (st.rx_class)
                    RX_BS:
                    begin
                        if (st.slot_free)
                        begin
                            cmd.emit = 1'b1;
                            if (st.len_zero)
                            begin
                                cmd.src    = SRC_BELL;
                                cmd.last   = 1'b1;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                cmd.src    = SRC_BS;
                                cmd.len_op = LEN_DEC;
                                state_next = S_BS_SPACE;
                            end
                        end
                    end
                    RX_CR:
                    begin
                        // read address 0 so the first byte is ready next cycle
                        cmd.ptr_op = PTR_ZERO;
                        state_next = st.len_zero ? S_CR_LF : S_CR_DATA;
                    end
                    RX_FF:
                    begin
                        if (st.slot_free)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.src    = SRC_FF;
                            cmd.last   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    RX_KILL_LINE:
                    begin
                        cmd.num_op = NUM_LEN;
                        cmd.len_op = LEN_ZERO;
                        state_next = S_ER_ESC1;
                    end
                    RX_KILL_WORD:
                    begin
                        if (st.len_zero)
                            state_next = S_IDLE;
                        else
                        begin
                            cmd.ptr_op  = PTR_LOAD_LEN;
                            cmd.rd_back = 1'b1;
                            state_next  = S_KW_BLANK;
                        end
                    end
                    RX_OTHER:
                    begin
                        if (st.slot_free)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.last   = 1'b1;
                            state_next = S_IDLE;
                            if (st.len_below_limit)
                            begin
                                cmd.src    = SRC_RX;
                                cmd.len_op = LEN_APPEND;
                            end
                            else
                                cmd.src = SRC_BELL;
                        end
                    end
                    default:
                        state_next = S_IDLE;
                endcase
            end

            S_BS_SPACE:
            begin
                if (st.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.src    = SRC_SPACE;
                    state_next = S_BS_END;
                end
            end

            S_BS_END:
            begin
                if (st.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.src    = SRC_BS;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_CR_DATA:
            begin
                if (st.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.src    = SRC_MEM;
                    cmd.kind   = KIND_LINE;
                    cmd.ptr_op = PTR_INC;
                    if (st.ptr_at_end)
                        state_next = S_CR_LF;
                end
            end

            S_CR_LF:
            begin
                if (st.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.src    = SRC_LF;
                    cmd.last   = 1'b1;
                    cmd.len_op = LEN_ZERO;
                    state_next = S_IDLE;
                end
            end

            S_KW_BLANK:
            begin
                cmd.rd_back = 1'b1;
                if (!st.ptr_zero && st.mem_blank)
                    cmd.ptr_op = PTR_DEC;
                else
                    state_next = S_KW_WORD;
            end

            S_KW_WORD:
            begin
                cmd.rd_back = 1'b1;
                if (!st.ptr_zero && !st.mem_blank)
                    cmd.ptr_op = PTR_DEC;
                else
                begin
                    cmd.num_op = NUM_LEN_MINUS_PTR;
                    cmd.len_op = LEN_FROM_PTR;
                    state_next = S_ER_ESC1;
                end
            end

            S_ER_ESC1:
            begin
                if (st.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.src    = SRC_ESC;
                    state_next = S_ER_LBR1;
                end
            end

            S_ER_LBR1:
            begin
                if (st.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.src    = SRC_LBRACKET;
                    state_next = st.tens_zero ? S_ER_ONES : S_ER_TENS;
                end
            end

            S_ER_TENS:
            begin
                if (st.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.src    = SRC_TENS;
                    state_next = S_ER_ONES;
                end
            end

            S_ER_ONES:
            begin
                if (st.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.src    = SRC_ONES;
                    state_next = S_ER_D;
                end
            end

            S_ER_D:
            begin
                if (st.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.src    = SRC_LETTER_D;
                    state_next = S_ER_ESC2;
                end
            end

            S_ER_ESC2:
            begin
                if (st.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.src    = SRC_ESC;
                    state_next = S_ER_LBR2;
                end
            end

            S_ER_LBR2:
            begin
                if (st.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.src    = SRC_LBRACKET;
                    state_next = S_ER_K;
                end
            end

            S_ER_K:
            begin
                if (st.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.src    = SRC_LETTER_K;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // the final result of a request always returns the sequencer to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.last) |=> (state_reg == S_IDLE))
        else $error("sequencer did not return to idle after last result");

    // a request is dispatched right after it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_DISPATCH))
        else $error("accepted request was not dispatched");

endmodule

/* rtl/tle_datapath.sv */
module tle_datapath
    import tle_pkg::*;
#(
    parameter int LINE_DEPTH = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       line_capacity_we,
    input  logic [5:0] line_capacity_wdata,
    input  logic       in_accept,
    input  logic [7:0] in_byte,
    input  cmd_t       cmd,
    output status_t    st,
    output logic       tx_valid,
    input  logic       tx_ready,
    output logic       tx_kind,
    output logic [7:0] tx_byte,
    output logic       tx_last
);

    localparam int LEN_W = $clog2(LINE_DEPTH + 1);
    localparam int IDX_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    logic [7:0]       line_mem [LINE_DEPTH];
    logic [7:0]       rd_data_reg;
    logic [5:0]       capacity_reg;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [LEN_W-1:0] ptr_reg;
    logic [LEN_W-1:0] ptr_next;
    logic [LEN_W-1:0] num_reg;
    logic [LEN_W-1:0] num_next;
    logic [7:0]       rx_reg;
    logic             tx_valid_reg;
    logic             tx_kind_reg;
    logic [7:0]       tx_byte_reg;
    logic             tx_last_reg;
    logic [LEN_W-1:0] rd_addr_full;
    logic [IDX_W-1:0] rd_addr;
    logic [12:0]      num_prod;
    logic [2:0]       tens;
    logic [3:0]       ones;
    logic [7:0]       src_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= CAPACITY_RESET;
        else if (line_capacity_we)
            capacity_reg <= line_capacity_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            rx_reg <= in_byte;
    end

    always_comb
    begin
        unique case (cmd.len_op)
            LEN_ZERO:     len_next = '0;
            LEN_DEC:      len_next = len_reg - LEN_W'(1);
            LEN_APPEND:   len_next = len_reg + LEN_W'(1);
            LEN_FROM_PTR: len_next = ptr_reg;
            default:      len_next = len_reg;
        endcase
    end

    always_comb
    begin
        unique case (cmd.ptr_op)
            PTR_ZERO:     ptr_next = '0;
            PTR_LOAD_LEN: ptr_next = len_reg;
            PTR_INC:      ptr_next = ptr_reg + LEN_W'(1);
            PTR_DEC:      ptr_next = ptr_reg - LEN_W'(1);
            default:      ptr_next = ptr_reg;
        endcase
    end

    always_comb
    begin
        unique case (cmd.num_op)
            NUM_LEN:           num_next = len_reg;
            NUM_LEN_MINUS_PTR: num_next = len_reg - ptr_reg;
            default:           num_next = num_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_reg <= '0;
        else
            len_reg <= len_next;
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        num_reg <= num_next;
    end

    // backward scans read one entry behind the pointer, line readout at it
    assign rd_addr_full = ptr_next - (cmd.rd_back ? LEN_W'(1) : LEN_W'(0));
    assign rd_addr      = rd_addr_full[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.len_op == LEN_APPEND)
            line_mem[len_reg[IDX_W-1:0]] <= rx_reg;
        rd_data_reg <= line_mem[rd_addr];
    end

    // decimal split of the erase count: n * 103 / 1024 is n / 10 below 100
    assign num_prod = 13'(num_reg) * 13'd103;
    assign tens     = num_prod[12:10];
    assign ones     = 4'(7'(num_reg) - 7'(tens) * 7'd10);

    always_comb
    begin
        unique case (cmd.src)
            SRC_BELL:     src_byte = CH_BELL;
            SRC_BS:       src_byte = CH_BS;
            SRC_SPACE:    src_byte = CH_SPACE;
            SRC_LF:       src_byte = CH_LF;
            SRC_FF:       src_byte = CH_FF;
            SRC_ESC:      src_byte = CH_ESC;
            SRC_LBRACKET: src_byte = CH_LBRACKET;
            SRC_LETTER_D: src_byte = CH_LETTER_D;
            SRC_LETTER_K: src_byte = CH_LETTER_K;
            SRC_RX:       src_byte = rx_reg;
            SRC_MEM:      src_byte = rd_data_reg;
            SRC_TENS:     src_byte = CH_DIGIT_BASE | {5'b0, tens};
            SRC_ONES:     src_byte = CH_DIGIT_BASE | {4'b0, ones};
            default:      src_byte = CH_BELL;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tx_valid_reg <= 1'b0;
        else if (cmd.emit)
            tx_valid_reg <= 1'b1;
        else if (tx_ready)
            tx_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            tx_kind_reg <= cmd.kind;
            tx_byte_reg <= src_byte;
            tx_last_reg <= cmd.last;
        end
    end

    assign tx_valid = tx_valid_reg;
    assign tx_kind  = tx_kind_reg;
    assign tx_byte  = tx_byte_reg;
    assign tx_last  = tx_last_reg;

    assign st.rx_class        = classify(rx_reg);
    assign st.len_zero        = (len_reg == '0);
    assign st.len_below_limit = (7'(len_reg) < 7'(capacity_reg))
                             && (7'(len_reg) < 7'(LINE_DEPTH));
    assign st.ptr_zero        = (ptr_reg == '0);
    assign st.ptr_at_end      = ((ptr_reg + LEN_W'(1)) == len_reg);
    assign st.mem_blank       = is_blank(rd_data_reg);
    assign st.tens_zero       = (tens == 3'd0);
    assign st.slot_free       = !tx_valid_reg || tx_ready;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> st.slot_free)
        else $error("result loaded over one not yet taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.len_op == LEN_APPEND) |-> st.len_below_limit)
        else $error("append past line limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        32'(len_reg) <= 32'(LINE_DEPTH))
        else $error("line length beyond storage depth");

endmodule
